// ----- rtl/core/cfto_pkg.sv -----
`timescale 1ns / 1ps

package cfto_pkg;

  // Request kinds carried on in_tuser
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_MARK   = 1'b1;

  // Field widths of one request and one result
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int USER_W  = 64;
  localparam int STAMP_W = 32;
  localparam int ROW_W   = 6;

  // Flow key = {proto, port, dst, src}; table key adds the user above it
  localparam int FLOW_W  = 2 * ADDR_W + PORT_W + PROTO_W;
  localparam int KEY_W   = FLOW_W + USER_W;
  // Status word = {password_seen, stamp}
  localparam int STAT_W  = STAMP_W + 1;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    OUT_DROPPED   = 3'd0,
    OUT_REFRESHED = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_REPLACED  = 3'd3,
    OUT_MARKED    = 3'd4,
    OUT_NO_FLOW   = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESP
  } state_t;

endpackage

// ----- rtl/core/cfto_ram.sv -----
`timescale 1ns / 1ps

module cfto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/coalescing_flow_table_oldest_evict_core.sv -----
`timescale 1ns / 1ps
// Flow: a request is accepted only in idle; it then walks the table with one read per
//   valid row through a single read port, waits for the last read to return, and
//   passes a decide step, where any table write is made, and a response step. The
//   result waits in the response step for out_tready to free the output register.
// Throughput: one request at a time; the next request is accepted only once the
//   result has been loaded into the output register and the block is idle again.
// A dropped record request skips the table walk and goes straight to the response step.
// Reset (rst_n low, synchronous) empties the table by clearing the row count; row storage
//   is not cleared, since rows at or above the count are never read.
module coalescing_flow_table_oldest_evict_core
  import cfto_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit up: src_addr[31:0], dst_addr[31:0], dest_port_num[15:0],
  //   protocol_code[7:0], user_present, user_key[63:0], now_seconds[31:0], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type (0 record user exposure, 1 mark password seen)
  input  logic                  in_tuser,
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit up: outcome[2:0], row_index[5:0], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // ---------------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;        // number of valid rows
  logic [CW-1:0]       iss_r, iss_nxt;        // next row to read
  logic                pend_r, pend_nxt;      // read data for pidx_r arrives this cycle
  logic [AW-1:0]       pidx_r, pidx_nxt;

  // Request payload, held for the whole walk
  logic                kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [STAMP_W-1:0]  now_r, now_nxt;

  // Candidate tracking: newest flow row for a mark, oldest row for a record
  logic                sel_found_r, sel_found_nxt;
  logic [AW-1:0]       sel_idx_r, sel_idx_nxt;
  logic [STAMP_W-1:0]  sel_stamp_r, sel_stamp_nxt;

  // First exact match for a record
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic                hit_flag_r, hit_flag_nxt;

  // Result waiting for the output register
  outcome_t            res_code_r, res_code_nxt;
  logic [ROW_W-1:0]    res_row_r, res_row_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Table storage: key memory and status memory, same row addressing
  // ---------------------------------------------------------------------------
  logic                key_we, stat_we;
  logic [AW-1:0]       waddr, raddr;
  logic [KEY_W-1:0]    key_wdata, key_rdata;
  logic [STAT_W-1:0]   stat_wdata, stat_rdata;

  cfto_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  cfto_ram #(
    .WIDTH (STAT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (waddr),
    .wdata (stat_wdata),
    .raddr (raddr),
    .rdata (stat_rdata)
  );

  // ---------------------------------------------------------------------------
  // Row compare and the shared stamp comparator
  // ---------------------------------------------------------------------------
  logic                flow_eq, user_eq;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [STAMP_W-1:0]  cmp_a, cmp_b;
  logic                cmp_lt;

  assign flow_eq  = (key_rdata[FLOW_W-1:0] == key_r[FLOW_W-1:0]);
  assign user_eq  = (key_rdata[KEY_W-1:FLOW_W] == key_r[KEY_W-1:FLOW_W]);
  assign rd_stamp = stat_rdata[STAMP_W-1:0];

  // Mark looks for a strictly newer stamp, record for a strictly older one;
  // strict compares keep the lowest index on ties.
  assign cmp_a  = (kind_r == REQ_MARK) ? sel_stamp_r : rd_stamp;
  assign cmp_b  = (kind_r == REQ_MARK) ? rd_stamp : sel_stamp_r;
  assign cmp_lt = (cmp_a < cmp_b);

  assign raddr = iss_r[AW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    sel_found_nxt = sel_found_r;
    sel_idx_nxt   = sel_idx_r;
    sel_stamp_nxt = sel_stamp_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_flag_nxt  = hit_flag_r;
    res_code_nxt  = res_code_r;
    res_row_nxt   = res_row_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    key_we        = 1'b0;
    stat_we       = 1'b0;
    waddr         = '0;
    key_wdata     = key_r;
    stat_wdata    = {1'b0, now_r};
    in_tready     = 1'b0;

    // Drop the output once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt      = in_tuser;
          key_nxt       = {in_tdata[152:89], in_tdata[87:0]};
          now_nxt       = in_tdata[184:153];
          iss_nxt       = '0;
          sel_found_nxt = 1'b0;
          sel_stamp_nxt = '0;
          sel_idx_nxt   = '0;
          hit_nxt       = 1'b0;
          if (in_tuser == REQ_RECORD && !in_tdata[88]) begin
            // Empty user: answer at once, table untouched
            res_code_nxt = OUT_DROPPED;
            res_row_nxt  = '0;
            state_nxt    = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one row read per cycle
        if (iss_r < cnt_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[AW-1:0];
          iss_nxt  = iss_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = ST_DECIDE;
        end
        // Evaluate the row whose data just came back
        if (pend_r) begin
          if (kind_r == REQ_MARK) begin
            if (flow_eq && (!sel_found_r || cmp_lt)) begin
              sel_found_nxt = 1'b1;
              sel_idx_nxt   = pidx_r;
              sel_stamp_nxt = rd_stamp;
            end
          end else begin
            if (flow_eq && user_eq && !hit_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = pidx_r;
              hit_flag_nxt = stat_rdata[STAMP_W];
            end
            if (!sel_found_r || cmp_lt) begin
              sel_found_nxt = 1'b1;
              sel_idx_nxt   = pidx_r;
              sel_stamp_nxt = rd_stamp;
            end
          end
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_RESP;
        if (kind_r == REQ_MARK) begin
          if (sel_found_r) begin
            stat_we      = 1'b1;
            waddr        = sel_idx_r;
            stat_wdata   = {1'b1, now_r};
            res_code_nxt = OUT_MARKED;
            res_row_nxt  = ROW_W'(sel_idx_r);
          end else begin
            res_code_nxt = OUT_NO_FLOW;
            res_row_nxt  = '0;
          end
        end else if (hit_r) begin
          // Refresh the stamp, keep the flag
          stat_we      = 1'b1;
          waddr        = hit_idx_r;
          stat_wdata   = {hit_flag_r, now_r};
          res_code_nxt = OUT_REFRESHED;
          res_row_nxt  = ROW_W'(hit_idx_r);
        end else if (cnt_r < DEPTH_C) begin
          key_we       = 1'b1;
          stat_we      = 1'b1;
          waddr        = cnt_r[AW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
          res_code_nxt = OUT_INSERTED;
          res_row_nxt  = ROW_W'(cnt_r[AW-1:0]);
        end else begin
          key_we       = 1'b1;
          stat_we      = 1'b1;
          waddr        = sel_idx_r;
          res_code_nxt = OUT_REPLACED;
          res_row_nxt  = ROW_W'(sel_idx_r);
        end
      end

      ST_RESP: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W - ROW_W - 3){1'b0}}, res_row_r, res_code_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    pidx_r      <= pidx_nxt;
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    sel_found_r <= sel_found_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_stamp_r <= sel_stamp_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_flag_r  <= hit_flag_nxt;
    res_code_r  <= res_code_nxt;
    res_row_r   <= res_row_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("row count above table depth");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new request taken while one is in flight");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && res_code_nxt == OUT_INSERTED) |=>
      (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not advance the row count");

  a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (key_we || stat_we) |-> (state_r == ST_DECIDE))
    else $error("table written outside the decide step");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cfto_pkg::*;

  localparam int DEPTH = 64;
  // Zero bits above now_seconds in in_tdata
  localparam int PAD_W = IN_DATA_W - (FLOW_W + 1 + USER_W + STAMP_W);

  // Stamp styles for the pooled random traffic
  localparam int STAMP_TIED   = 0;  // few distinct values, lots of ties
  localparam int STAMP_RISING = 1;  // slowly rising clock, true oldest eviction
  localparam int STAMP_WILD   = 2;  // full 32-bit range
  localparam int STAMP_MIXED  = 3;  // pick one of the above per request

  typedef struct {
    logic               kind;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [PORT_W-1:0]  port;
    logic [PROTO_W-1:0] proto;
    logic               user_present;
    logic [USER_W-1:0]  user;
    logic [STAMP_W-1:0] now;
  } flow_req_t;

  typedef struct {
    outcome_t         outcome;
    logic [ROW_W-1:0] row;
  } flow_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = REQ_RECORD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the flow table
  int unsigned        shadow_count = 0;
  logic [ADDR_W-1:0]  shadow_src   [DEPTH];
  logic [ADDR_W-1:0]  shadow_dst   [DEPTH];
  logic [PORT_W-1:0]  shadow_port  [DEPTH];
  logic [PROTO_W-1:0] shadow_proto [DEPTH];
  logic [USER_W-1:0]  shadow_user  [DEPTH];
  logic               shadow_seen  [DEPTH];
  logic [STAMP_W-1:0] shadow_stamp [DEPTH];

  // Outcomes still owed by the table, oldest first
  flow_result_t pending_outcomes[$];

  int errors = 0;
  int requests_sent = 0;
  int outcome_tally[6] = '{default: 0};
  bit steady = 1'b0;  // suppress all idling on both sides while set

  // Random traffic draws its flows from a small pool so that hits, near misses,
  // table fill and eviction all happen often
  logic [ADDR_W-1:0]  pool_src   [2];
  logic [ADDR_W-1:0]  pool_dst   [2];
  logic [PORT_W-1:0]  pool_port  [2];
  logic [PROTO_W-1:0] pool_proto [2];
  logic [USER_W-1:0]  pool_user  [8];
  logic [STAMP_W-1:0] clock_now = '0;

  coalescing_flow_table_oldest_evict_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    // Cap the log; the count keeps going
    if (errors <= 100) begin
      $display("MISMATCH at %0t: %s, got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic bit flow_hit(input int unsigned i, input flow_req_t r);
    return shadow_src[i] == r.src && shadow_dst[i] == r.dst &&
           shadow_port[i] == r.port && shadow_proto[i] == r.proto;
  endfunction

  // Apply one request to the shadow table and work out the outcome it owes.
  task automatic apply_request(input flow_req_t r, output flow_result_t res);
    int unsigned slot;
    bit found;
    res.outcome = OUT_NO_FLOW;
    res.row = '0;
    slot = 0;
    found = 1'b0;
    if (r.kind == REQ_MARK) begin
      // Newest row of the flow; strict compare keeps the lowest index on ties
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (flow_hit(i, r) && (!found || shadow_stamp[i] > shadow_stamp[slot])) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        shadow_seen[slot] = 1'b1;
        shadow_stamp[slot] = r.now;
        res.outcome = OUT_MARKED;
        res.row = ROW_W'(slot);
      end
    end else if (!r.user_present) begin
      res.outcome = OUT_DROPPED;
    end else begin
      // Full tuple search, first hit wins
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (!found && flow_hit(i, r) && shadow_user[i] == r.user) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        shadow_stamp[slot] = r.now;
        res.outcome = OUT_REFRESHED;
      end else begin
        if (shadow_count < DEPTH) begin
          slot = shadow_count;
          shadow_count++;
          res.outcome = OUT_INSERTED;
        end else begin
          // Oldest stamp goes; lowest index on ties
          for (int unsigned i = 1; i < DEPTH; i++) begin
            if (shadow_stamp[i] < shadow_stamp[slot]) slot = i;
          end
          res.outcome = OUT_REPLACED;
        end
        shadow_src[slot] = r.src;
        shadow_dst[slot] = r.dst;
        shadow_port[slot] = r.port;
        shadow_proto[slot] = r.proto;
        shadow_user[slot] = r.user;
        shadow_seen[slot] = 1'b0;
        shadow_stamp[slot] = r.now;
      end
      res.row = ROW_W'(slot);
    end
  endtask

  function automatic flow_req_t make_req(input logic kind, input logic [ADDR_W-1:0] src,
                                         input logic [ADDR_W-1:0] dst,
                                         input logic [PORT_W-1:0] port,
                                         input logic [PROTO_W-1:0] proto,
                                         input logic present, input logic [USER_W-1:0] user,
                                         input logic [STAMP_W-1:0] now);
    flow_req_t r;
    r.kind = kind;
    r.src = src;
    r.dst = dst;
    r.port = port;
    r.proto = proto;
    r.user_present = present;
    r.user = user;
    r.now = now;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then predict its outcome.
  task automatic send_request(input flow_req_t r);
    flow_result_t res;
    // Random idle gap; valid drops only here, never twice in one step
    while (!steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {{PAD_W{1'b0}}, r.now, r.user, r.user_present, r.proto, r.port,
                  r.dst, r.src};
    do @(posedge clk); while (!in_tready);
    apply_request(r, res);
    pending_outcomes.push_back(res);
    requests_sent++;
  endtask

  // Check each accepted result against the oldest pending outcome, then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    flow_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request pending", 64'(out_tdata), 64'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_tdata[2:0] !== want.outcome) begin
          report_mismatch("outcome", 64'(out_tdata[2:0]), 64'(want.outcome));
        end
        if (out_tdata[3 +: ROW_W] !== want.row) begin
          report_mismatch("row_index", 64'(out_tdata[3 +: ROW_W]), 64'(want.row));
        end
        if (out_tdata[OUT_DATA_W-1:3+ROW_W] !== '0) begin
          report_mismatch("pad bits", 64'(out_tdata), 64'(0));
        end
        outcome_tally[want.outcome]++;
      end
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
  end

  // Refill the flow pool: two candidates per flow field and eight users, so many
  // requests differ from a stored flow in one field only. Extremes put all-zero and
  // all-one values into every flow-field slot and into the first two user slots.
  task automatic refill_pool(input bit extremes);
    for (int i = 0; i < 2; i++) begin
      pool_src[i]   = extremes ? {ADDR_W{i[0]}} : $urandom;
      pool_dst[i]   = extremes ? {ADDR_W{~i[0]}} : $urandom;
      pool_port[i]  = extremes ? {PORT_W{i[0]}} : PORT_W'($urandom);
      pool_proto[i] = extremes ? {PROTO_W{~i[0]}} : PROTO_W'($urandom);
    end
    for (int i = 0; i < 8; i++) begin
      pool_user[i] = {$urandom, $urandom};
    end
    if (extremes) begin
      pool_user[0] = '0;
      pool_user[1] = '1;
    end
  endtask

  function automatic flow_req_t pooled_request(input int stamp_mode);
    flow_req_t r;
    int roll;
    int style;
    roll = $urandom_range(99);
    r.kind = (roll < 22) ? REQ_MARK : REQ_RECORD;
    // Roughly one record in ten carries an empty user
    r.user_present = (roll < 22) ? 1'($urandom) : (roll >= 30);
    if ($urandom_range(99) < 12) begin
      // Noise: a flow that is almost never stored
      r.src = $urandom;
      r.dst = $urandom;
      r.port = PORT_W'($urandom);
      r.proto = PROTO_W'($urandom);
      r.user = {$urandom, $urandom};
    end else begin
      r.src = pool_src[$urandom_range(1)];
      r.dst = pool_dst[$urandom_range(1)];
      r.port = pool_port[$urandom_range(1)];
      r.proto = pool_proto[$urandom_range(1)];
      r.user = pool_user[$urandom_range(7)];
    end
    style = (stamp_mode == STAMP_MIXED) ? $urandom_range(STAMP_WILD) : stamp_mode;
    case (style)
      STAMP_TIED: begin
        r.now = STAMP_W'($urandom_range(15));
      end
      STAMP_RISING: begin
        clock_now = clock_now + STAMP_W'($urandom_range(3));
        r.now = clock_now;
      end
      default: begin
        r.now = $urandom;
      end
    endcase
    return r;
  endfunction

  task automatic run_pooled(input int count, input int stamp_mode);
    repeat (count) send_request(pooled_request(stamp_mode));
  endtask

  // Drop, no flow, insert, refresh and mark on field extremes.
  task automatic test_basic_outcomes();
    send_request(make_req(REQ_MARK, '1, '1, '1, '1, 1'b1, '1, 32'd5));
    send_request(make_req(REQ_RECORD, '1, '1, '1, '1, 1'b0, '1, '1));
    send_request(make_req(REQ_RECORD, '0, '0, '0, '0, 1'b1, '0, '0));
    send_request(make_req(REQ_RECORD, '0, '0, '0, '0, 1'b1, '0, 32'd1));
    send_request(make_req(REQ_RECORD, '1, '1, '1, '1, 1'b1, '1, '1));
    send_request(make_req(REQ_MARK, '1, '1, '1, '1, 1'b0, '0, 32'd77));
    // Differs in protocol only
    send_request(make_req(REQ_MARK, '1, '1, '1, 8'hFE, 1'b1, '1, 32'd78));
    send_request(make_req(REQ_RECORD, '0, '0, '0, '0, 1'b1, '1, 32'd1));
    // Two rows of the all-zero flow with equal stamps: lowest index marked
    send_request(make_req(REQ_MARK, '0, '0, '0, '0, 1'b1, '0, 32'h8000_0000));
    send_request(make_req(REQ_RECORD, '0, '0, '0, '0, 1'b0, '0, '0));
  endtask

  // Several users on one flow with equal stamps, then marks that walk the
  // newest row as stamps change.
  task automatic test_mark_ties();
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] d;
    logic [PORT_W-1:0] p;
    logic [PROTO_W-1:0] pr;
    logic [USER_W-1:0] u [3];
    s = $urandom;
    d = $urandom;
    p = PORT_W'($urandom);
    pr = PROTO_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      u[i] = {$urandom, $urandom};
      send_request(make_req(REQ_RECORD, s, d, p, pr, 1'b1, u[i], 32'd100));
    end
    send_request(make_req(REQ_MARK, s, d, p, pr, 1'b0, '0, 32'd100));
    send_request(make_req(REQ_MARK, s, d, p, pr, 1'b1, '1, 32'd50));
    send_request(make_req(REQ_MARK, s, d, p, pr, 1'b0, '0, 32'd7));
    send_request(make_req(REQ_RECORD, s, d, p, pr, 1'b1, u[1], 32'd200));
    send_request(make_req(REQ_MARK, s, d, p, pr, 1'b1, '0, 32'd9));
    send_request(make_req(REQ_MARK, s, d, p ^ 16'h0001, pr, 1'b1, '0, 32'd9));
  endtask

  // Fill the table and evict under heavy stamp ties.
  task automatic test_eviction_ties();
    refill_pool(1'b0);
    run_pooled(600, STAMP_TIED);
  endtask

  // Rising stamps make the oldest row well defined; start with a long
  // stretch where neither side idles.
  task automatic test_oldest_eviction();
    refill_pool(1'b0);
    steady = 1'b1;
    run_pooled(250, STAMP_RISING);
    steady = 1'b0;
    run_pooled(350, STAMP_RISING);
  endtask

  // Flows and users built from all-zero and all-one fields.
  task automatic test_extreme_fields();
    refill_pool(1'b1);
    run_pooled(300, STAMP_MIXED);
  endtask

  task automatic test_random_mix();
    refill_pool(1'b0);
    run_pooled(430, STAMP_MIXED);
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_outcomes();
    test_mark_ties();
    test_eviction_ties();
    test_oldest_eviction();
    test_extreme_fields();
    test_random_mix();

    // Stop offering requests and drain the outstanding results
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // Give a stray extra result time to show up
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      report_mismatch("results never delivered", 64'(pending_outcomes.size()), 64'd0);
    end

    $display("Sent %0d requests; table left with %0d rows.", requests_sent, shadow_count);
    $display("Results: %0d dropped, %0d refreshed, %0d inserted, %0d replaced, %0d marked, %0d no flow.",
             outcome_tally[OUT_DROPPED], outcome_tally[OUT_REFRESHED],
             outcome_tally[OUT_INSERTED], outcome_tally[OUT_REPLACED],
             outcome_tally[OUT_MARKED], outcome_tally[OUT_NO_FLOW]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", pending_outcomes.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cfto_pkg.sv
rtl/core/cfto_ram.sv
rtl/core/coalescing_flow_table_oldest_evict_core.sv
bench/tb.sv
